// ----- hdl/tcm_pkg.sv -----
package tcm_pkg;

    localparam int RUN_MAX         = 6;
    localparam int RUN_IDX_W       = 3;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;

    localparam logic [1:0] MODE_TDM  = 2'd0;
    localparam logic [1:0] MODE_STDM = 2'd1;
    localparam logic [1:0] MODE_FDM  = 2'd2;
    localparam logic [1:0] MODE_CDM  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b1;

    localparam logic [1:0]  MODE_RESET     = MODE_TDM;
    localparam logic [15:0] CAPACITY_RESET = 16'd64;

    localparam logic [7:0] TAG_A     = 8'd1;
    localparam logic [7:0] TAG_B     = 8'd2;
    localparam logic [7:0] CHIP_HIGH = 8'd130;
    localparam logic [7:0] CHIP_MID  = 8'd128;
    localparam logic [7:0] CHIP_LOW  = 8'd126;

    // one slot's worth of output bytes, bytes[0] goes out first
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [15:0]             base;
        logic [RUN_IDX_W-1:0]    len;
    } t_run;

endpackage

// ----- hdl/tcm_in_if.sv -----
interface tcm_in_if;
    logic       valid;
    logic       ready;
    logic       first_slot;
    logic [7:0] a_byte;
    logic       a_present;
    logic [7:0] b_byte;
    logic       b_present;

    modport source (
        output valid, first_slot, a_byte, a_present, b_byte, b_present,
        input  ready
    );
    modport sink (
        input  valid, first_slot, a_byte, a_present, b_byte, b_present,
        output ready
    );
endinterface

// ----- hdl/tcm_out_if.sv -----
interface tcm_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [15:0] bytes_so_far;

    modport source (
        output valid, out_byte, last_of_run, bytes_so_far,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last_of_run, bytes_so_far,
        output ready
    );
endinterface

// ----- hdl/tcm_front.sv -----
module tcm_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcm_in_if.sink                          i_in,
    input  logic                            i_cfg_we,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output tcm_pkg::t_run                   o_q_data
);
    import tcm_pkg::*;

    logic [1:0]  r_mode;
    logic [15:0] r_cap;
    logic [15:0] r_bc, n_bc;
    logic [7:0]  r_sn, n_sn;

    logic [15:0] bc;
    logic [7:0]  sn;
    logic [16:0] bc17, cap17, bc_a;
    logic        ea, eb, accept;
    logic [7:0]  a, b;
    t_run        run;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign a          = i_in.a_byte;
    assign b          = i_in.b_byte;

    always_comb begin
        bc    = i_in.first_slot ? 16'd0 : r_bc;
        sn    = i_in.first_slot ? 8'd0 : r_sn;
        bc17  = {1'b0, bc};
        cap17 = {1'b0, r_cap};
        ea    = 1'b0;
        eb    = 1'b0;
        bc_a  = bc17;
        run   = '0;
        run.base = bc;
        case (r_mode)
            MODE_TDM: begin
                ea   = i_in.a_present && (bc17 + 17'd1 <= cap17);
                bc_a = bc17 + {16'd0, ea};
                eb   = i_in.b_present && (bc_a + 17'd1 <= cap17);
                run.bytes[0] = ea ? a : b;
                run.bytes[1] = b;
                run.len      = {2'b0, ea} + {2'b0, eb};
            end
            MODE_STDM: begin
                ea   = i_in.a_present && (a != 8'd0) && (bc17 + 17'd3 <= cap17);
                bc_a = bc17 + (ea ? 17'd3 : 17'd0);
                eb   = i_in.b_present && (b != 8'd0) && (bc_a + 17'd3 <= cap17);
                if (ea) begin
                    run.bytes[0] = TAG_A;
                    run.bytes[1] = sn;
                    run.bytes[2] = a;
                    run.bytes[3] = TAG_B;
                    run.bytes[4] = sn;
                    run.bytes[5] = b;
                end else begin
                    run.bytes[0] = TAG_B;
                    run.bytes[1] = sn;
                    run.bytes[2] = b;
                end
                run.len = (ea && eb) ? 3'd6 : ((ea || eb) ? 3'd3 : 3'd0);
            end
            MODE_FDM: begin
                ea = (i_in.a_present || i_in.b_present) && (bc17 + 17'd1 <= cap17);
                run.bytes[0] = {i_in.b_present ? b[3:0] : 4'd0,
                                i_in.a_present ? a[3:0] : 4'd0};
                run.len = {2'b0, ea};
            end
            MODE_CDM: begin
                ea = i_in.a_present && i_in.b_present && (bc17 + 17'd2 <= cap17);
                if ((a != 8'd0) && (b != 8'd0)) begin
                    run.bytes[0] = CHIP_HIGH;
                    run.bytes[1] = CHIP_MID;
                end else if (a != 8'd0) begin
                    run.bytes[0] = CHIP_MID;
                    run.bytes[1] = CHIP_HIGH;
                end else if (b != 8'd0) begin
                    run.bytes[0] = CHIP_MID;
                    run.bytes[1] = CHIP_LOW;
                end else begin
                    run.bytes[0] = CHIP_LOW;
                    run.bytes[1] = CHIP_MID;
                end
                run.len = ea ? 3'd2 : 3'd0;
            end
            default: begin
                run.len = 3'd0;
            end
        endcase
        n_bc = bc + {13'd0, run.len};
        n_sn = sn + 8'd1;
    end

    assign o_q_push = accept && (run.len != 3'd0);
    assign o_q_data = run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_cap  <= CAPACITY_RESET;
            r_bc   <= '0;
            r_sn   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:     r_mode <= i_cfg_data[1:0];
                    CFG_CAPACITY: r_cap  <= i_cfg_data;
                    default:      r_mode <= r_mode;
                endcase
            end
            if (accept) begin
                r_bc <= n_bc;
                r_sn <= n_sn;
            end
        end
    end

endmodule

// ----- hdl/tcm_queue.sv -----
module tcm_queue #(
    parameter int DEPTH = tcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcm_pkg::t_run i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tcm_pkg::t_run o_data
);
    import tcm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_run             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/tcm_back.sv -----
module tcm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  tcm_pkg::t_run i_q_data,
    output logic          o_q_pop,
    tcm_out_if.source     o_out
);
    import tcm_pkg::*;

    logic [RUN_IDX_W-1:0] r_k;
    logic                 r_ov;
    logic [7:0]           r_ob;
    logic                 r_last;
    logic [15:0]          r_cnt;
    logic                 load, last;

    assign load    = i_q_valid && (!r_ov || o_out.ready);
    assign last    = (r_k == i_q_data.len - RUN_IDX_W'(1));
    assign o_q_pop = load && last;

    assign o_out.valid        = r_ov;
    assign o_out.out_byte     = r_ob;
    assign o_out.last_of_run  = r_last;
    assign o_out.bytes_so_far = r_cnt;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ob   <= i_q_data.bytes[r_k];
            r_last <= last;
            r_cnt  <= i_q_data.base + {13'd0, r_k} + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_k  <= '0;
        end else begin
            if (load) begin
                r_ov <= 1'b1;
                r_k  <= last ? '0 : r_k + RUN_IDX_W'(1);
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/two_channel_multiplexer_top.sv -----
// Two-channel byte multiplexer.
// i_in carries one time slot per item: a byte and a presence flag for each
// of channels A and B, plus first_slot to restart the frame. o_out carries
// the multiplexed bytes, one per item, with last_of_run on the final byte of
// a slot and bytes_so_far counting bytes in the current frame.
// Config writes (i_cfg_we/i_cfg_idx/i_cfg_data) set mode (index 0) and
// capacity (index 1); write them only while no slot is in flight.
// The first byte of a slot passes through the run queue and then the output
// register before it is valid. Throughput: one output byte per cycle while
// the receiver is ready; a slot produces one to six bytes. The front
// classifies one slot per cycle, while the queue is not full, into a run
// queue of QUEUE_DEPTH entries; the back drains one byte per cycle from its
// head while the receiver is ready. Slots with no output are absorbed by
// the front and never queued. If the receiver stalls, the output register
// holds, the queue fills and i_in.ready drops. Reset: mode TDM, capacity
// 64, byte and slot counts zero, queue empty.
module two_channel_multiplexer_top #(
    parameter int QUEUE_DEPTH = tcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcm_in_if.sink                          i_in,
    tcm_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import tcm_pkg::*;

    logic q_push, q_full, q_pop, q_valid;
    t_run q_in, q_out;

    tcm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    tcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    tcm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ----- tb/tcm_checker.sv -----
`timescale 1ns / 100ps

module tcm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tcm_in_if                               i_in,
    tcm_out_if                              i_out,
    input  logic                            i_cfg_we,
    input  logic [tcm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import tcm_pkg::*;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic [15:0] bytes_so_far;
    } t_mux_byte;

    logic [1:0]  mode_q;
    logic [15:0] capacity_q;
    logic [15:0] byte_count_q;
    logic [7:0]  slot_q;

    t_mux_byte slot_run[$];
    t_mux_byte mux_expected[$];

    function automatic logic room_for(input int n);
        return (17'(byte_count_q) + 17'(n)) <= 17'(capacity_q);
    endfunction

    function automatic void put_mux_byte(input logic [7:0] v);
        byte_count_q = byte_count_q + 16'd1;
        slot_run.push_back('{out_byte: v, last_of_run: 1'b0, bytes_so_far: byte_count_q});
    endfunction

    function automatic void mux_slot(input logic fs, input logic [7:0] a, input logic ap,
                                     input logic [7:0] b, input logic bp);
        t_mux_byte tail;
        int        sa;
        int        sb;
        if (fs) begin
            byte_count_q = '0;
            slot_q       = '0;
        end
        slot_run.delete();
        case (mode_q)
            MODE_TDM: begin
                if (ap && room_for(1)) put_mux_byte(a);
                if (bp && room_for(1)) put_mux_byte(b);
            end
            MODE_STDM: begin
                if (ap && a != 8'd0 && room_for(3)) begin
                    put_mux_byte(TAG_A);
                    put_mux_byte(slot_q);
                    put_mux_byte(a);
                end
                if (bp && b != 8'd0 && room_for(3)) begin
                    put_mux_byte(TAG_B);
                    put_mux_byte(slot_q);
                    put_mux_byte(b);
                end
            end
            MODE_FDM: begin
                if ((ap || bp) && room_for(1))
                    put_mux_byte({bp ? b[3:0] : 4'h0, ap ? a[3:0] : 4'h0});
            end
            default: begin
                if (ap && bp && room_for(2)) begin
                    sa = (a != 8'd0) ? 1 : -1;
                    sb = (b != 8'd0) ? 1 : -1;
                    put_mux_byte(8'(sa + sb) + CHIP_MID);
                    put_mux_byte(8'(sa - sb) + CHIP_MID);
                end
            end
        endcase
        if (slot_run.size() > 0) begin
            tail = slot_run.pop_back();
            tail.last_of_run = 1'b1;
            slot_run.push_back(tail);
        end
        foreach (slot_run[i]) mux_expected.push_back(slot_run[i]);
        slot_q = slot_q + 8'd1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_mux_byte exp_byte;
        if (!i_rst_n) begin
            mode_q       = MODE_RESET;
            capacity_q   = CAPACITY_RESET;
            byte_count_q = '0;
            slot_q       = '0;
            mux_expected.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MODE)
                    mode_q = i_cfg_data[1:0];
                else if (i_cfg_idx == CFG_CAPACITY)
                    capacity_q = i_cfg_data[15:0];
            end
            if (i_in.valid && i_in.ready)
                mux_slot(i_in.first_slot, i_in.a_byte, i_in.a_present, i_in.b_byte,
                         i_in.b_present);
            if (i_out.valid && i_out.ready) begin
                if (mux_expected.size() == 0) begin
                    $error("unexpected item: out_byte %0d last_of_run %0d bytes_so_far %0d",
                           i_out.out_byte, i_out.last_of_run, i_out.bytes_so_far);
                    o_fail_count++;
                end else begin
                    exp_byte = mux_expected.pop_front();
                    if (i_out.out_byte !== exp_byte.out_byte) begin
                        $error("out_byte: expected %0d, actual %0d",
                               exp_byte.out_byte, i_out.out_byte);
                        o_fail_count++;
                    end
                    if (i_out.last_of_run !== exp_byte.last_of_run) begin
                        $error("last_of_run: expected %0d, actual %0d",
                               exp_byte.last_of_run, i_out.last_of_run);
                        o_fail_count++;
                    end
                    if (i_out.bytes_so_far !== exp_byte.bytes_so_far) begin
                        $error("bytes_so_far: expected %0d, actual %0d",
                               exp_byte.bytes_so_far, i_out.bytes_so_far);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = mux_expected.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import tcm_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 10;
    localparam int WIDE_PHASES  = 6;

    localparam logic [1:0] PH_MODE [NUM_PHASES] = '{
        MODE_STDM, MODE_TDM, MODE_CDM, MODE_FDM, MODE_STDM,
        MODE_STDM, MODE_TDM, MODE_STDM, MODE_CDM, MODE_FDM
    };
    localparam int PH_IDLE  [NUM_PHASES] = '{0, 88, 0, 31, 0, 88, 0, 31, 88, 0};
    localparam int PH_STALL [NUM_PHASES] = '{0, 0, 88, 31, 0, 0, 88, 31, 0, 0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    hold_left = 0;
    int                    cycle_count = 0;

    tcm_in_if  in_ch ();
    tcm_out_if out_ch ();

    two_channel_multiplexer_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tcm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver: long hold-off first, else random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready = 1'b0;
            hold_left--;
        end else begin
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0, 1:    return 8'h00;
            2:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_slot(input logic fs, input logic [7:0] a, input logic ap,
                             input logic [7:0] b, input logic bp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.first_slot = fs;
        in_ch.a_byte     = a;
        in_ch.a_present  = ap;
        in_ch.b_byte     = b;
        in_ch.b_present  = bp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random(input int fs_pct);
        send_slot($urandom_range(99) < fs_pct, rand_byte(), $urandom_range(99) < 80,
                  rand_byte(), $urandom_range(99) < 80);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    initial begin
        int n_items;
        int fs_pct;
        logic [15:0] cap;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        in_ch.valid      = 1'b0;
        in_ch.first_slot = 1'b0;
        in_ch.a_byte     = '0;
        in_ch.a_present  = 1'b0;
        in_ch.b_byte     = '0;
        in_ch.b_present  = 1'b0;
        out_ch.ready     = 1'b0;
        send_idle_pct    = 31;
        recv_stall_pct   = 31;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // TDM at reset settings
        send_slot(1'b1, 8'h00, 1'b1, 8'hFF, 1'b1);
        send_slot(1'b0, 8'hFF, 1'b1, 8'h00, 1'b0);
        send_slot(1'b0, 8'h5A, 1'b0, 8'hA5, 1'b1);
        send_slot(1'b0, 8'h12, 1'b0, 8'h34, 1'b0);
        drain();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_STDM));
        send_slot(1'b0, 8'h00, 1'b1, 8'h00, 1'b1);
        send_slot(1'b0, 8'hFF, 1'b1, 8'h01, 1'b1);
        send_slot(1'b0, 8'h00, 1'b1, 8'h80, 1'b1);
        drain();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_FDM));
        send_slot(1'b0, 8'hAB, 1'b1, 8'hCD, 1'b1);
        send_slot(1'b0, 8'hF7, 1'b1, 8'h3E, 1'b0);
        send_slot(1'b0, 8'h00, 1'b0, 8'hFF, 1'b1);
        send_slot(1'b0, 8'hFF, 1'b0, 8'hFF, 1'b0);
        drain();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_CDM));
        send_slot(1'b0, 8'h00, 1'b1, 8'h00, 1'b1);
        send_slot(1'b0, 8'h00, 1'b1, 8'h07, 1'b1);
        send_slot(1'b0, 8'h09, 1'b1, 8'h00, 1'b1);
        send_slot(1'b0, 8'hFF, 1'b1, 8'hFF, 1'b1);
        send_slot(1'b0, 8'hFF, 1'b1, 8'hFF, 1'b0);
        drain();
        // record that no longer fits is dropped whole
        write_reg(CFG_CAPACITY, 16'd4);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_STDM));
        send_slot(1'b1, 8'h11, 1'b1, 8'h22, 1'b1);
        send_slot(1'b0, 8'h33, 1'b1, 8'h00, 1'b0);
        drain();
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_TDM));
        send_slot(1'b0, 8'h44, 1'b1, 8'h55, 1'b1);
        send_slot(1'b1, 8'h66, 1'b1, 8'h77, 1'b1);
        drain();
        // capacity below current count acts as full
        write_reg(CFG_CAPACITY, 16'd1);
        send_slot(1'b0, 8'h88, 1'b1, 8'h99, 1'b1);
        send_slot(1'b1, 8'h88, 1'b1, 8'h99, 1'b1);
        drain();
        write_reg(CFG_CAPACITY, 16'd0);
        send_slot(1'b1, 8'hFF, 1'b1, 8'hFF, 1'b1);
        drain();
        write_reg(CFG_CAPACITY, 16'hFFFF);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_CDM));
        send_slot(1'b1, 8'h01, 1'b1, 8'h02, 1'b1);

        // wide phases run without frame restarts so the slot number wraps
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            if (ph < WIDE_PHASES) begin
                cap     = 16'hFFFF;
                fs_pct  = 0;
                n_items = 45;
            end else begin
                cap     = 16'($urandom_range(40));
                fs_pct  = 15;
                n_items = 15;
            end
            write_reg(CFG_MODE, CFG_DATA_W'(PH_MODE[ph]));
            write_reg(CFG_CAPACITY, cap);
            send_idle_pct  = PH_IDLE[ph];
            recv_stall_pct = PH_STALL[ph];
            if (ph == 0) begin
                @(posedge i_clk);
                hold_left = 300;
            end
            repeat (n_items) send_random(fs_pct);
        end
        drain();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/tcm_pkg.sv
hdl/tcm_in_if.sv
hdl/tcm_out_if.sv
hdl/tcm_front.sv
hdl/tcm_queue.sv
hdl/tcm_back.sv
hdl/two_channel_multiplexer_top.sv
tb/tcm_checker.sv
tb/tb.sv
